@@ rtl/tcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console package
// Geometry, codes, payload types and address helpers shared by the console.
// ----------------------------------------------------------------------------
package tcs_pkg;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int HISTORY_ROWS = 64;

   localparam int SCREEN_SIZE = SCREEN_COLS * SCREEN_ROWS;
   localparam int HIST_SIZE   = SCREEN_COLS * HISTORY_ROWS;
   localparam int DEPTH_CAP   = HISTORY_ROWS - SCREEN_ROWS;

   localparam int COL_W   = $clog2(SCREEN_COLS);
   localparam int ROW_W   = $clog2(SCREEN_ROWS);
   localparam int HROW_W  = $clog2(HISTORY_ROWS);
   localparam int SADDR_W = $clog2(SCREEN_SIZE);
   localparam int HADDR_W = $clog2(HIST_SIZE);
   localparam int DEPTH_W = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  NL_CODE     = 8'd10;
   localparam logic [7:0]  SPACE_CODE  = 8'h20;
   localparam logic [7:0]  RESET_COLOR = 8'h09;
   localparam logic [15:0] HIDDEN_POS  = 16'hFFFF;

   localparam logic [2:0] KIND_PUT   = 3'd0;
   localparam logic [2:0] KIND_ERASE = 3'd1;
   localparam logic [2:0] KIND_CLEAR = 3'd2;
   localparam logic [2:0] KIND_UP    = 3'd3;
   localparam logic [2:0] KIND_DOWN  = 3'd4;
   localparam logic [2:0] KIND_READ  = 3'd5;

   localparam int               CSR_ADDR_W     = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEXT_COLOR = 3'd0;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_ERASE,
      OP_CLEAR,
      OP_UP,
      OP_DOWN,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_code;
      logic [7:0]  fill_color;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [15:0] cursor_pos;
      logic [15:0] cell_data;
      logic [5:0]  view_depth;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         ch;
      logic [7:0]         fill;
      logic [SADDR_W-1:0] addr;
      logic               in_range;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qlink_type;

   function automatic logic [15:0] cell_pos(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
      logic [31:0] p;
      p = 32'(row) * 32'(SCREEN_COLS) + 32'(col);
      return p[15:0];
   endfunction

   function automatic logic [SADDR_W-1:0] screen_addr(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
      logic [31:0] a;
      a = 32'(row) * 32'(SCREEN_COLS) + 32'(col);
      return a[SADDR_W-1:0];
   endfunction

   // history row is (row + ring) mod HISTORY_ROWS; the sum stays below twice that
   function automatic logic [HADDR_W-1:0] hist_addr(input logic [ROW_W-1:0]  row,
                                                     input logic [COL_W-1:0]  col,
                                                     input logic [HROW_W-1:0] ring);
      logic [HROW_W:0] r;
      logic [31:0]     a;
      r = (HROW_W+1)'(ring) + (HROW_W+1)'(row);
      if (r >= (HROW_W+1)'(HISTORY_ROWS)) begin
         r = r - (HROW_W+1)'(HISTORY_ROWS);
      end
      a = 32'(r) * 32'(SCREEN_COLS) + 32'(col);
      return a[HADDR_W-1:0];
   endfunction

   // first history cell shown at the top of the view
   function automatic logic [HADDR_W-1:0] view_addr(input logic [HROW_W-1:0]  ring,
                                                     input logic [DEPTH_W-1:0] depth);
      logic [HROW_W:0] r;
      logic [31:0]     a;
      r = (HROW_W+1)'(ring) + (HROW_W+1)'(HISTORY_ROWS) - (HROW_W+1)'(depth);
      if (r >= (HROW_W+1)'(HISTORY_ROWS)) begin
         r = r - (HROW_W+1)'(HISTORY_ROWS);
      end
      a = 32'(r) * 32'(SCREEN_COLS);
      return a[HADDR_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/tcs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console front end
// Accepts request beats, decodes them into commands and hands them to the queue.
// ----------------------------------------------------------------------------
module tcs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tcs_pkg::req_type   req_data,
   input  wire logic               init_done,
   input  wire logic               q_ready,
   output tcs_pkg::qlink_type      q_push
);

   logic             hold_valid_ff;
   tcs_pkg::cmd_type cmd_ff;
   tcs_pkg::cmd_type cmd_in;
   logic             accept;

   always_comb begin
      cmd_in.ch       = req_data.char_code;
      cmd_in.fill     = req_data.fill_color;
      cmd_in.addr     = tcs_pkg::SADDR_W'(req_data.cell_address);
      cmd_in.in_range = 32'(req_data.cell_address) < 32'(tcs_pkg::SCREEN_SIZE);
      case (req_data.kind)
         tcs_pkg::KIND_PUT: begin
            cmd_in.op = (req_data.char_code == tcs_pkg::NL_CODE) ?
                        tcs_pkg::OP_NEWLINE : tcs_pkg::OP_PUT;
         end
         tcs_pkg::KIND_ERASE: cmd_in.op = tcs_pkg::OP_ERASE;
         tcs_pkg::KIND_CLEAR: cmd_in.op = tcs_pkg::OP_CLEAR;
         tcs_pkg::KIND_UP:    cmd_in.op = tcs_pkg::OP_UP;
         tcs_pkg::KIND_DOWN:  cmd_in.op = tcs_pkg::OP_DOWN;
         tcs_pkg::KIND_READ:  cmd_in.op = tcs_pkg::OP_READ;
         default:             cmd_in.op = tcs_pkg::OP_NOP;
      endcase
   end

   assign req_ready    = init_done && (!hold_valid_ff || q_ready);
   assign accept       = req_valid && req_ready;
   assign q_push.valid = hold_valid_ff;
   assign q_push.cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (accept) begin
         hold_valid_ff <= 1'b1;
      end else if (q_ready) begin
         hold_valid_ff <= 1'b0;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tcs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console command queue
// Short queue that decouples command decode from command execution.
// ----------------------------------------------------------------------------
module tcs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tcs_pkg::qlink_type  push,
   output logic                     push_ready,
   output tcs_pkg::qlink_type       head,
   input  wire logic                pop
);

   tcs_pkg::cmd_type                 entry_ff [tcs_pkg::QUEUE_DEPTH];
   logic [tcs_pkg::QPTR_W-1:0]       wr_ff;
   logic [tcs_pkg::QPTR_W-1:0]       rd_ff;
   logic [tcs_pkg::QPTR_W:0]         count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = count_ff != (tcs_pkg::QPTR_W+1)'(tcs_pkg::QUEUE_DEPTH);
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == tcs_pkg::QPTR_W'(tcs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == tcs_pkg::QPTR_W'(tcs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push.cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tcs_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Console execution engine
// Runs commands against the screen and history stores and returns results.
// ----------------------------------------------------------------------------
module tcs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tcs_pkg::qlink_type  head,
   output logic                     pop,
   input  wire logic [7:0]          text_color,
   output logic                     init_done,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output tcs_pkg::rsp_type         rsp_data
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADDR,
      ST_PUT,
      ST_ERASE,
      ST_SHIFT,
      ST_BLANKSET,
      ST_BLANK,
      ST_TAIL,
      ST_VIEW,
      ST_RELOAD,
      ST_CLEAR,
      ST_READ,
      ST_RESP
   } state_type;

   state_type                       state_ff;
   tcs_pkg::cmd_type                cmd_ff;
   logic                            wc_ff;
   logic [tcs_pkg::ROW_W-1:0]       row_ff;
   logic [tcs_pkg::COL_W-1:0]       col_ff;
   logic [tcs_pkg::HROW_W-1:0]      ring_ff;
   logic [tcs_pkg::DEPTH_W-1:0]     depth_ff;
   logic [tcs_pkg::DEPTH_W-1:0]     limit_ff;
   logic [15:0]                     curreg_ff;
   logic [tcs_pkg::SADDR_W-1:0]     saddr_ff;
   logic [tcs_pkg::HADDR_W-1:0]     haddr_ff;
   logic [tcs_pkg::SADDR_W-1:0]     swp_ff;
   logic [tcs_pkg::COL_W-1:0]       cnt_ff;
   logic [tcs_pkg::HADDR_W-1:0]     init_ff;
   logic                            pend_ff;
   logic                            pend_hist_ff;
   logic [tcs_pkg::SADDR_W-1:0]     pend_addr_ff;
   logic                            rsp_valid_ff;
   tcs_pkg::rsp_type                rsp_data_ff;

   logic [15:0] scr_mem  [tcs_pkg::SCREEN_SIZE];
   logic [15:0] hist_mem [tcs_pkg::HIST_SIZE];
   logic [15:0] scr_rdata_ff;
   logic [15:0] hist_rdata_ff;

   logic                         scr_we;
   logic [tcs_pkg::SADDR_W-1:0]  scr_waddr;
   logic [tcs_pkg::SADDR_W-1:0]  scr_raddr;
   logic [15:0]                  scr_wdata;
   logic                         hist_we;
   logic [tcs_pkg::HADDR_W-1:0]  hist_waddr;
   logic [15:0]                  hist_wdata;

   logic [tcs_pkg::HADDR_W-1:0]  haddr_next;
   logic [15:0]                  blank_text;
   logic [15:0]                  resp_cursor;
   tcs_pkg::rsp_type             resp_next;
   logic                         col_last;
   logic                         row_last;

   assign haddr_next = (haddr_ff == tcs_pkg::HADDR_W'(tcs_pkg::HIST_SIZE - 1)) ?
                       '0 : haddr_ff + 1'b1;
   assign blank_text = {text_color, tcs_pkg::SPACE_CODE};
   assign col_last   = col_ff == tcs_pkg::COL_W'(tcs_pkg::SCREEN_COLS - 1);
   assign row_last   = row_ff == tcs_pkg::ROW_W'(tcs_pkg::SCREEN_ROWS - 1);

   assign pop       = (state_ff == ST_IDLE) && head.valid;
   assign init_done = state_ff != ST_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (!wc_ff) begin
         resp_cursor = curreg_ff;
      end else if (depth_ff != '0) begin
         resp_cursor = tcs_pkg::HIDDEN_POS;
      end else begin
         resp_cursor = tcs_pkg::cell_pos(row_ff, col_ff);
      end
      resp_next.cursor_pos = resp_cursor;
      resp_next.cell_data  = (cmd_ff.op == tcs_pkg::OP_READ && cmd_ff.in_range) ?
                             scr_rdata_ff : 16'h0000;
      resp_next.view_depth = (cmd_ff.op == tcs_pkg::OP_CLEAR) ? '0 : depth_ff;
   end

   // store ports
   always_comb begin
      scr_we     = 1'b0;
      scr_waddr  = saddr_ff;
      scr_wdata  = blank_text;
      hist_we    = 1'b0;
      hist_waddr = haddr_ff;
      hist_wdata = blank_text;
      scr_raddr  = (state_ff == ST_SHIFT) ?
                   swp_ff + tcs_pkg::SADDR_W'(tcs_pkg::SCREEN_COLS) : cmd_ff.addr;
      if (pend_ff) begin
         scr_we    = 1'b1;
         scr_waddr = pend_addr_ff;
         scr_wdata = pend_hist_ff ? hist_rdata_ff : scr_rdata_ff;
      end
      case (state_ff)
         ST_INIT: begin
            scr_we     = 32'(init_ff) < 32'(tcs_pkg::SCREEN_SIZE);
            scr_waddr  = init_ff[tcs_pkg::SADDR_W-1:0];
            scr_wdata  = {tcs_pkg::RESET_COLOR, tcs_pkg::SPACE_CODE};
            hist_we    = 1'b1;
            hist_waddr = init_ff;
            hist_wdata = 16'h0000;
         end
         ST_PUT: begin
            scr_we  = 1'b1;
            hist_we = 1'b1;
            if (cmd_ff.op == tcs_pkg::OP_PUT) begin
               scr_wdata  = {text_color, cmd_ff.ch};
               hist_wdata = {text_color, cmd_ff.ch};
            end
         end
         ST_ERASE, ST_BLANK: begin
            scr_we  = 1'b1;
            hist_we = 1'b1;
         end
         ST_CLEAR: begin
            scr_we     = 1'b1;
            hist_we    = 1'b1;
            scr_wdata  = {cmd_ff.fill, tcs_pkg::SPACE_CODE};
            hist_wdata = {cmd_ff.fill, tcs_pkg::SPACE_CODE};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      scr_rdata_ff <= scr_mem[scr_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rdata_ff <= hist_mem[haddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         wc_ff        <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         ring_ff      <= '0;
         depth_ff     <= '0;
         limit_ff     <= '0;
         curreg_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // copy writes land in the cycle after their read
         pend_ff <= (state_ff == ST_SHIFT) || (state_ff == ST_RELOAD);
         if (rsp_valid_ff && rsp_ready && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == tcs_pkg::HADDR_W'(tcs_pkg::HIST_SIZE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (head.valid) begin
                  cmd_ff <= head.cmd;
                  case (head.cmd.op)
                     tcs_pkg::OP_PUT, tcs_pkg::OP_NEWLINE: begin
                        wc_ff    <= 1'b1;
                        state_ff <= ST_ADDR;
                     end
                     tcs_pkg::OP_ERASE: begin
                        wc_ff <= 1'b1;
                        if (col_ff == '0) begin
                           col_ff <= tcs_pkg::COL_W'(tcs_pkg::SCREEN_COLS - 1);
                           if (row_ff != '0) begin
                              row_ff <= row_ff - 1'b1;
                           end
                        end else begin
                           col_ff <= col_ff - 1'b1;
                        end
                        state_ff <= ST_ADDR;
                     end
                     tcs_pkg::OP_CLEAR: begin
                        wc_ff    <= 1'b1;
                        row_ff   <= '0;
                        col_ff   <= '0;
                        state_ff <= ST_ADDR;
                     end
                     tcs_pkg::OP_UP: begin
                        if (depth_ff < limit_ff) begin
                           wc_ff    <= 1'b1;
                           depth_ff <= depth_ff + 1'b1;
                           state_ff <= ST_VIEW;
                        end else begin
                           wc_ff    <= 1'b0;
                           state_ff <= ST_RESP;
                        end
                     end
                     tcs_pkg::OP_DOWN: begin
                        if (depth_ff != '0) begin
                           wc_ff    <= 1'b1;
                           depth_ff <= depth_ff - 1'b1;
                           state_ff <= ST_VIEW;
                        end else begin
                           wc_ff    <= 1'b0;
                           state_ff <= ST_RESP;
                        end
                     end
                     tcs_pkg::OP_READ: begin
                        wc_ff    <= 1'b0;
                        state_ff <= ST_READ;
                     end
                     default: begin
                        wc_ff    <= 1'b0;
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_ADDR: begin
               saddr_ff <= tcs_pkg::screen_addr(row_ff, col_ff);
               haddr_ff <= tcs_pkg::hist_addr(row_ff, col_ff, ring_ff);
               case (cmd_ff.op)
                  tcs_pkg::OP_PUT, tcs_pkg::OP_NEWLINE: state_ff <= ST_PUT;
                  tcs_pkg::OP_ERASE:                    state_ff <= ST_ERASE;
                  tcs_pkg::OP_CLEAR:                    state_ff <= ST_CLEAR;
                  default:                              state_ff <= ST_RESP;
               endcase
            end
            ST_PUT: begin
               saddr_ff <= saddr_ff + 1'b1;
               haddr_ff <= haddr_next;
               if (cmd_ff.op == tcs_pkg::OP_PUT || col_last) begin
                  if (col_last) begin
                     col_ff <= '0;
                     if (row_last) begin
                        // bottom wrap: advance the ring and move the screen up
                        ring_ff <= (ring_ff == tcs_pkg::HROW_W'(tcs_pkg::HISTORY_ROWS - 1)) ?
                                   '0 : ring_ff + 1'b1;
                        if (limit_ff < tcs_pkg::DEPTH_W'(tcs_pkg::DEPTH_CAP)) begin
                           limit_ff <= limit_ff + 1'b1;
                        end
                        swp_ff   <= '0;
                        state_ff <= ST_SHIFT;
                     end else begin
                        row_ff   <= row_ff + 1'b1;
                        state_ff <= ST_TAIL;
                     end
                  end else begin
                     col_ff   <= col_ff + 1'b1;
                     state_ff <= ST_TAIL;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            ST_SHIFT: begin
               pend_hist_ff <= 1'b0;
               pend_addr_ff <= swp_ff;
               swp_ff       <= swp_ff + 1'b1;
               if (swp_ff == tcs_pkg::SADDR_W'(tcs_pkg::SCREEN_SIZE -
                                               tcs_pkg::SCREEN_COLS - 1)) begin
                  state_ff <= ST_BLANKSET;
               end
            end
            ST_BLANKSET: begin
               saddr_ff <= tcs_pkg::screen_addr(tcs_pkg::ROW_W'(tcs_pkg::SCREEN_ROWS - 1), '0);
               haddr_ff <= tcs_pkg::hist_addr(tcs_pkg::ROW_W'(tcs_pkg::SCREEN_ROWS - 1), '0,
                                              ring_ff);
               cnt_ff   <= '0;
               state_ff <= ST_BLANK;
            end
            ST_BLANK: begin
               saddr_ff <= saddr_ff + 1'b1;
               haddr_ff <= haddr_next;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == tcs_pkg::COL_W'(tcs_pkg::SCREEN_COLS - 1)) begin
                  state_ff <= ST_TAIL;
               end
            end
            ST_TAIL: begin
               // a put while viewing history snaps the view back to the live screen
               if (depth_ff != '0) begin
                  depth_ff <= '0;
                  state_ff <= ST_VIEW;
               end else begin
                  state_ff <= ST_RESP;
               end
            end
            ST_VIEW: begin
               saddr_ff <= '0;
               haddr_ff <= tcs_pkg::view_addr(ring_ff, depth_ff);
               state_ff <= ST_RELOAD;
            end
            ST_RELOAD: begin
               pend_hist_ff <= 1'b1;
               pend_addr_ff <= saddr_ff;
               saddr_ff     <= saddr_ff + 1'b1;
               haddr_ff     <= haddr_next;
               if (saddr_ff == tcs_pkg::SADDR_W'(tcs_pkg::SCREEN_SIZE - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_ERASE: state_ff <= ST_RESP;
            ST_CLEAR: begin
               saddr_ff <= saddr_ff + 1'b1;
               haddr_ff <= haddr_next;
               if (saddr_ff == tcs_pkg::SADDR_W'(tcs_pkg::SCREEN_SIZE - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_READ: state_ff <= ST_RESP;
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= resp_next;
                  curreg_ff    <= resp_cursor;
                  if (cmd_ff.op == tcs_pkg::OP_CLEAR) begin
                     depth_ff <= '0;
                     limit_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/text_console_with_scrollback_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console with scrollback
// Character terminal with a visible screen store and a circular history ring.
//
//   channel | ports               | direction | beat
//   req     | req_valid/req_ready | in        | req_type command
//   rsp     | rsp_valid/rsp_ready | out       | rsp_type result
//   csr     | csr_psel/penable    | in        | text_color register
//
// Each request beat is answered by one result beat. A newline pads the rest of
// its row with blanks. A bottom-row wrap walks the screen store once, and a view
// change or a put while scrolled back reloads it from history; clear writes every
// screen cell. Each store has a single write port. After reset the stores are
// swept while req_ready stays low. A stalled result holds in the output register
// while the next command waits in the queue.
// ----------------------------------------------------------------------------
module text_console_with_scrollback_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire tcs_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output tcs_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   logic               color_we;
   logic [7:0]         color_ff;
   logic               init_done;
   logic               q_ready;
   logic               q_pop;
   tcs_pkg::qlink_type q_push;
   tcs_pkg::qlink_type q_head;
   logic               csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr == tcs_pkg::CSR_TEXT_COLOR;
   assign csr_prdata = csr_hit ? {24'h000000, color_ff} : 32'h00000000;
   assign color_we   = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= tcs_pkg::RESET_COLOR;
      end else if (color_we) begin
         color_ff <= csr_pwdata[7:0];
      end
   end

   tcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .init_done (init_done),
      .q_ready   (q_ready),
      .q_push    (q_push)
   );

   tcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_ready),
      .head       (q_head),
      .pop        (q_pop)
   );

   tcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .text_color (color_ff),
      .init_done  (init_done),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_depth_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.view_depth) <= 32'(tcs_pkg::DEPTH_CAP)))
      else $error("view depth beyond history limit");

   a_hidden_cursor : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.view_depth != '0) |-> (rsp_data.cursor_pos == tcs_pkg::HIDDEN_POS))
      else $error("cursor shown while viewing history");

   a_no_accept_in_sweep : assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !req_ready)
      else $error("request taken during store sweep");
`endif

endmodule
`default_nettype wire
